### rtl/crdg_pkg.sv
// Shared constants, types and register codes for the camera ray direction generator.
`timescale 1ns / 1ps
`default_nettype none
package crdg_pkg;

   localparam int COORD_BITS  = 12;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 48;
   localparam int BASIS_W     = 16;
   localparam int WORD_W      = 32;
   localparam int U_W         = COORD_BITS + 34;
   localparam int PROD_W      = U_W + BASIS_W;
   localparam int D_W         = PROD_W + 2;
   localparam int BL_W        = $clog2(D_W + 1);
   localparam int NRM_W       = 30;
   localparam int SQ_W        = 2 * NRM_W + 2;
   localparam int ROOT_W      = NRM_W + 1;
   localparam int SQRT_STAGES = ROOT_W;
   localparam int FRAC_W      = 16;
   localparam int Q_W         = FRAC_W + 1;
   localparam int DIV_STAGES  = Q_W;
   localparam int NUM_W       = NRM_W + FRAC_W + 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_U_START,
      CSR_U_STEP,
      CSR_V_START,
      CSR_V_STEP,
      CSR_RIGHT_BASIS,
      CSR_UP_BASIS,
      CSR_VIEW_BASIS,
      CSR_NORMALIZE_ON
   } csr_idx_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] row;
      logic [COORD_BITS-1:0] col;
   } rc_type;

   typedef struct packed {
      rc_type                  rc;
      logic [2:0]              neg;
      logic                    zero;
      logic [2:0][WORD_W-1:0]  raw;
   } side_type;

   typedef logic [2:0][NRM_W-1:0] mag3_type;
   typedef logic [2:0][Q_W-1:0]   quot3_type;

endpackage
`default_nettype wire

### rtl/crdg_coord.sv
// Screen coordinate stages: u and v from pixel position, start and step.
`timescale 1ns / 1ps
`default_nettype none
module crdg_coord
   import crdg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire rc_type                in_rc,
   input  wire logic [WORD_W-1:0]     u_start,
   input  wire logic [WORD_W-1:0]     u_step,
   input  wire logic [WORD_W-1:0]     v_start,
   input  wire logic [WORD_W-1:0]     v_step,
   output logic                       out_valid,
   output rc_type                     out_rc,
   output logic signed [U_W-1:0]      out_u,
   output logic signed [U_W-1:0]      out_v
);

   logic                  vld1_ff, vld2_ff;
   rc_type                rc1_ff, rc2_ff;
   logic signed [COORD_BITS+WORD_W:0] pu_in, pv_in, pu_ff, pv_ff;
   logic signed [U_W-1:0] u_in, v_in, u_ff, v_ff;

   // column and row are unsigned: add a zero sign bit
   assign pu_in = $signed({1'b0, in_rc.col}) * $signed(u_step);
   assign pv_in = $signed({1'b0, in_rc.row}) * $signed(v_step);
   assign u_in  = U_W'(pu_ff) + U_W'($signed(u_start));
   assign v_in  = U_W'(pv_ff) + U_W'($signed(v_start));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pu_ff  <= pu_in;
         pv_ff  <= pv_in;
         rc1_ff <= in_rc;
         u_ff   <= u_in;
         v_ff   <= v_in;
         rc2_ff <= rc1_ff;
      end
   end

   assign out_valid = vld2_ff;
   assign out_rc    = rc2_ff;
   assign out_u     = u_ff;
   assign out_v     = v_ff;

endmodule
`default_nettype wire

### rtl/crdg_dir.sv
// Direction stages: basis products, sum, magnitude, raw rounding, normalize shift, squares.
`timescale 1ns / 1ps
`default_nettype none
module crdg_dir
   import crdg_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  wire rc_type                 in_rc,
   input  wire logic signed [U_W-1:0]  in_u,
   input  wire logic signed [U_W-1:0]  in_v,
   input  wire logic [CSR_DATA_W-1:0]  right_basis,
   input  wire logic [CSR_DATA_W-1:0]  up_basis,
   input  wire logic [CSR_DATA_W-1:0]  view_basis,
   output logic                        out_valid,
   output side_type                    out_side,
   output mag3_type                    out_mag,
   output logic [SQ_W-1:0]             out_n2
);

   localparam int NST = 8;

   logic [NST-1:0] vld_ff;

   logic signed [PROD_W-1:0] tr_in [3], tu_in [3], tr_ff [3], tu_ff [3];
   logic signed [D_W-1:0]    d_in [3], d_ff [3];
   logic [D_W-1:0]           mag_in [3], mag5_ff [3], mag6_ff [3], mag7_ff [3];
   logic [2:0]               neg_in, neg5_ff;
   rc_type                   rc3_ff, rc4_ff, rc5_ff;
   logic [D_W-1:0]           m_in, m_ff;
   side_type                 side_in, side6_ff, side7_ff, side8_ff, side9_ff, side10_ff;
   logic [BL_W-1:0]          b_in, b_ff;
   mag3_type                 sm_in, sm8_ff, sm9_ff, sm10_ff;
   logic [2*NRM_W-1:0]       sq_in [3], sq_ff [3];
   logic [SQ_W-1:0]          n2_in, n2_ff;

   // products of u and v with the right and up components
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         tr_in[c] = in_u * $signed(right_basis[BASIS_W*c +: BASIS_W]);
         tu_in[c] = in_v * $signed(up_basis[BASIS_W*c +: BASIS_W]);
      end
   end

   // sum with the view term at Q.30
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         d_in[c] = D_W'(tr_ff[c]) + D_W'(tu_ff[c])
                 + (D_W'($signed(view_basis[BASIS_W*c +: BASIS_W])) <<< FRAC_W);
      end
   end

   // sign and magnitude
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         neg_in[c] = d_ff[c][D_W-1];
         mag_in[c] = neg_in[c] ? D_W'(-d_ff[c]) : D_W'(d_ff[c]);
      end
   end

   // largest magnitude and raw rounded, saturated result
   always_comb begin
      logic [D_W-1:0] r;
      m_in = mag5_ff[0];
      if (mag5_ff[1] > m_in) m_in = mag5_ff[1];
      if (mag5_ff[2] > m_in) m_in = mag5_ff[2];
      side_in.rc   = rc5_ff;
      side_in.neg  = neg5_ff;
      side_in.zero = (m_in == '0);
      for (int c = 0; c < 3; c++) begin
         r = (mag5_ff[c] + D_W'(8192)) >> 14;
         if (neg5_ff[c]) begin
            if (r > D_W'(64'h8000_0000)) side_in.raw[c] = 32'h8000_0000;
            else                        side_in.raw[c] = -r[WORD_W-1:0];
         end else begin
            if (r > D_W'(64'h7FFF_FFFF)) side_in.raw[c] = 32'h7FFF_FFFF;
            else                        side_in.raw[c] = r[WORD_W-1:0];
         end
      end
   end

   // bit length of the largest magnitude
   always_comb begin
      b_in = '0;
      for (int i = 0; i < D_W; i++) begin
         if (m_ff[i]) b_in = BL_W'(i + 1);
      end
   end

   // scale so the largest magnitude has exactly NRM_W bits
   always_comb begin
      logic [D_W-1:0] s;
      for (int c = 0; c < 3; c++) begin
         if (b_ff > BL_W'(NRM_W)) s = mag7_ff[c] >> (b_ff - BL_W'(NRM_W));
         else                     s = mag7_ff[c] << (BL_W'(NRM_W) - b_ff);
         sm_in[c] = s[NRM_W-1:0];
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sq_in[c] = sm8_ff[c] * sm8_ff[c];
      end
      n2_in = SQ_W'(sq_ff[0]) + SQ_W'(sq_ff[1]) + SQ_W'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            tr_ff[c]   <= tr_in[c];
            tu_ff[c]   <= tu_in[c];
            d_ff[c]    <= d_in[c];
            mag5_ff[c] <= mag_in[c];
            mag6_ff[c] <= mag5_ff[c];
            mag7_ff[c] <= mag6_ff[c];
            sq_ff[c]   <= sq_in[c];
         end
         rc3_ff    <= in_rc;
         rc4_ff    <= rc3_ff;
         rc5_ff    <= rc4_ff;
         neg5_ff   <= neg_in;
         m_ff      <= m_in;
         side6_ff  <= side_in;
         side7_ff  <= side6_ff;
         b_ff      <= b_in;
         side8_ff  <= side7_ff;
         sm8_ff    <= sm_in;
         side9_ff  <= side8_ff;
         sm9_ff    <= sm8_ff;
         side10_ff <= side9_ff;
         sm10_ff   <= sm9_ff;
         n2_ff     <= n2_in;
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_side  = side10_ff;
   assign out_mag   = sm10_ff;
   assign out_n2    = n2_ff;

endmodule
`default_nettype wire

### rtl/crdg_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module crdg_sqrt
   import crdg_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [SQ_W-1:0]   in_n2,
   input  wire mag3_type          in_mag,
   input  wire side_type          in_side,
   output logic                   out_valid,
   output logic [ROOT_W-1:0]      out_root,
   output mag3_type               out_mag,
   output side_type               out_side
);

   logic [SQ_W-1:0] rem_p [SQRT_STAGES+1];
   logic [SQ_W-1:0] res_p [SQRT_STAGES+1];
   logic [SQ_W-1:0] rem_in [SQRT_STAGES], rem_ff [SQRT_STAGES];
   logic [SQ_W-1:0] res_in [SQRT_STAGES], res_ff [SQRT_STAGES];
   logic            vld_ff [SQRT_STAGES];
   mag3_type        mag_ff [SQRT_STAGES];
   side_type        side_ff [SQRT_STAGES];

   assign rem_p[0] = in_n2;
   assign res_p[0] = '0;

   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
      localparam int K = SQRT_STAGES - 1 - s;
      logic [SQ_W-1:0] bitv, trial;

      assign bitv  = SQ_W'(1) << (2 * K);
      assign trial = res_p[s] + bitv;

      always_comb begin
         if (rem_p[s] >= trial) begin
            rem_in[s] = rem_p[s] - trial;
            res_in[s] = (res_p[s] >> 1) + bitv;
         end else begin
            rem_in[s] = rem_p[s];
            res_in[s] = res_p[s] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= (s == 0) ? in_valid : vld_ff[(s == 0) ? 0 : s - 1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in[s];
            res_ff[s]  <= res_in[s];
            mag_ff[s]  <= (s == 0) ? in_mag : mag_ff[(s == 0) ? 0 : s - 1];
            side_ff[s] <= (s == 0) ? in_side : side_ff[(s == 0) ? 0 : s - 1];
         end
      end

      assign rem_p[s+1] = rem_ff[s];
      assign res_p[s+1] = res_ff[s];
   end

   assign out_valid = vld_ff[SQRT_STAGES-1];
   assign out_root  = res_p[SQRT_STAGES][ROOT_W-1:0];
   assign out_mag   = mag_ff[SQRT_STAGES-1];
   assign out_side  = side_ff[SQRT_STAGES-1];

endmodule
`default_nettype wire

### rtl/crdg_div.sv
// Pipelined restoring divider, three lanes, one quotient bit per stage with rounding.
`timescale 1ns / 1ps
`default_nettype none
module crdg_div
   import crdg_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [ROOT_W-1:0] in_root,
   input  wire mag3_type          in_mag,
   input  wire side_type          in_side,
   output logic                   out_valid,
   output quot3_type              out_quot,
   output side_type               out_side
);

   logic [2:0][NUM_W-1:0] num_in, num_ff;
   logic [ROOT_W-1:0]     n0_ff;
   logic                  v0_ff;
   side_type              side0_ff;

   logic [2:0][NUM_W-1:0] rem_p [DIV_STAGES+1];
   quot3_type             q_p [DIV_STAGES+1];
   logic [ROOT_W-1:0]     n_p [DIV_STAGES+1];
   logic                  v_p [DIV_STAGES+1];
   side_type              side_p [DIV_STAGES+1];

   // numerator: magnitude in Q16 plus half the divisor for rounding
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         num_in[c] = {NUM_W'(in_mag[c]) << FRAC_W} + NUM_W'(in_root >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff   <= num_in;
         n0_ff    <= in_root;
         side0_ff <= in_side;
      end
   end

   assign rem_p[0]  = num_ff;
   assign q_p[0]    = '0;
   assign n_p[0]    = n0_ff;
   assign v_p[0]    = v0_ff;
   assign side_p[0] = side0_ff;

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      localparam int K = DIV_STAGES - 1 - s;
      logic [2:0][NUM_W-1:0] rem_in, rem_ff;
      quot3_type             q_in, q_ff;
      logic [NUM_W-1:0]      dsh;
      logic [ROOT_W-1:0]     n_ff;
      logic                  vld_ff;
      side_type              side_ff;

      assign dsh = NUM_W'(n_p[s]) << K;

      always_comb begin
         for (int c = 0; c < 3; c++) begin
            q_in[c] = q_p[s][c];
            if (rem_p[s][c] >= dsh) begin
               rem_in[c]  = rem_p[s][c] - dsh;
               q_in[c][K] = 1'b1;
            end else begin
               rem_in[c] = rem_p[s][c];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= v_p[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            q_ff    <= q_in;
            n_ff    <= n_p[s];
            side_ff <= side_p[s];
         end
      end

      assign rem_p[s+1]  = rem_ff;
      assign q_p[s+1]    = q_ff;
      assign n_p[s+1]    = n_ff;
      assign v_p[s+1]    = vld_ff;
      assign side_p[s+1] = side_ff;
   end

   assign out_valid = v_p[DIV_STAGES];
   assign out_quot  = q_p[DIV_STAGES];
   assign out_side  = side_p[DIV_STAGES];

endmodule
`default_nettype wire

### rtl/camera_ray_direction_gen_top.sv
// Top level of the pinhole camera primary ray direction generator.
// Throughput: one transaction per cycle; the pipeline holds as a whole only while a
// finished response waits under rsp_stall, and bubbles travel as cleared valid bits.
// Reset (synchronous, active high) empties the pipeline and sets the configuration registers to 0
// except normalize_on, which comes up as 1.
`timescale 1ns / 1ps
`default_nettype none
module camera_ray_direction_gen_top
   import crdg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [COORD_BITS-1:0] req_pixel_row,
   input  wire logic [COORD_BITS-1:0] req_pixel_col,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [COORD_BITS-1:0]      rsp_out_row,
   output logic [COORD_BITS-1:0]      rsp_out_col,
   output logic [WORD_W-1:0]          rsp_dir_x,
   output logic [WORD_W-1:0]          rsp_dir_y,
   output logic [WORD_W-1:0]          rsp_dir_z,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   logic [WORD_W-1:0]     u_start_ff, u_step_ff, v_start_ff, v_step_ff;
   logic [CSR_DATA_W-1:0] right_ff, up_ff, view_ff;
   logic                  norm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         u_start_ff <= '0;
         u_step_ff  <= '0;
         v_start_ff <= '0;
         v_step_ff  <= '0;
         right_ff   <= '0;
         up_ff      <= '0;
         view_ff    <= '0;
         norm_ff    <= 1'b1;
      end else if (csr_write_en) begin
         case (csr_idx_type'(csr_index))
            CSR_U_START:      u_start_ff <= csr_wdata[WORD_W-1:0];
            CSR_U_STEP:       u_step_ff  <= csr_wdata[WORD_W-1:0];
            CSR_V_START:      v_start_ff <= csr_wdata[WORD_W-1:0];
            CSR_V_STEP:       v_step_ff  <= csr_wdata[WORD_W-1:0];
            CSR_RIGHT_BASIS:  right_ff   <= csr_wdata;
            CSR_UP_BASIS:     up_ff      <= csr_wdata;
            CSR_VIEW_BASIS:   view_ff    <= csr_wdata;
            CSR_NORMALIZE_ON: norm_ff    <= csr_wdata[0];
            default:          norm_ff    <= norm_ff;
         endcase
      end
   end

   // advance every stage unless the response register holds an untaken transaction
   logic rsp_valid_ff;
   logic en;
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   rc_type req_rc;
   assign req_rc.row = req_pixel_row;
   assign req_rc.col = req_pixel_col;

   // u and v
   logic                  c_valid;
   rc_type                c_rc;
   logic signed [U_W-1:0] c_u, c_v;

   crdg_coord u_coord (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_rc     (req_rc),
      .u_start   (u_start_ff),
      .u_step    (u_step_ff),
      .v_start   (v_start_ff),
      .v_step    (v_step_ff),
      .out_valid (c_valid),
      .out_rc    (c_rc),
      .out_u     (c_u),
      .out_v     (c_v)
   );

   // direction, raw result, normalized magnitudes and sum of squares
   logic             d_valid;
   side_type         d_side;
   mag3_type         d_mag;
   logic [SQ_W-1:0]  d_n2;

   crdg_dir u_dir (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (c_valid),
      .in_rc       (c_rc),
      .in_u        (c_u),
      .in_v        (c_v),
      .right_basis (right_ff),
      .up_basis    (up_ff),
      .view_basis  (view_ff),
      .out_valid   (d_valid),
      .out_side    (d_side),
      .out_mag     (d_mag),
      .out_n2      (d_n2)
   );

   // vector length
   logic              s_valid;
   logic [ROOT_W-1:0] s_root;
   mag3_type          s_mag;
   side_type          s_side;

   crdg_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .in_n2     (d_n2),
      .in_mag    (d_mag),
      .in_side   (d_side),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_mag   (s_mag),
      .out_side  (s_side)
   );

   // unit vector components in Q16.16, rounded to nearest
   logic      q_valid;
   quot3_type q_quot;
   side_type  q_side;

   crdg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_root   (s_root),
      .in_mag    (s_mag),
      .in_side   (s_side),
      .out_valid (q_valid),
      .out_quot  (q_quot),
      .out_side  (q_side)
   );

   // response register: pick normalized or raw, apply sign, force zero direction to 0
   rc_type                 rsp_rc_ff;
   logic [2:0][WORD_W-1:0] dir_in, dir_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (!norm_ff)          dir_in[c] = q_side.raw[c];
         else if (q_side.zero)  dir_in[c] = '0;
         else if (q_side.neg[c]) dir_in[c] = -WORD_W'(q_quot[c]);
         else                   dir_in[c] = WORD_W'(q_quot[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_rc_ff <= q_side.rc;
         dir_ff    <= dir_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_row = rsp_rc_ff.row;
   assign rsp_out_col = rsp_rc_ff.col;
   assign rsp_dir_x   = dir_ff[0];
   assign rsp_dir_y   = dir_ff[1];
   assign rsp_dir_z   = dir_ff[2];

endmodule
`default_nettype wire
